// ----- design/crpf_pkg.sv -----
// ============================================================================
// Catmull-Rom path follower package
// Command and register codes, fixed datapath widths and saturation limits.
// ============================================================================
`default_nettype none

package crpf_pkg;

    // Commands carried by an input transaction.
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    localparam int SPEED_W = 16;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd128;

    // Segment index and point count width.
    localparam int IDX_W = 5;

    // Path parameter t: unsigned Q8.16, plus one bit for the look-ahead value.
    localparam int T_W  = 24;
    localparam int TE_W = 25;
    localparam logic [T_W-1:0]  T_ONE      = 24'h01_0000;
    localparam logic [T_W-1:0]  T_MAX      = 24'hFF_FFFF;
    localparam logic [TE_W-1:0] AIM_OFFSET = 25'd655;

    // Spline datapath: signed values held within +-2^61.
    localparam int ACC_W  = 63;
    localparam int SUM_W  = 64;
    localparam int MAG_W  = 62;
    localparam int HALF_W = 31;
    localparam int PP_W   = 56;
    localparam int PROD_W = 87;
    localparam int OUT_W  = 32;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [MAG_W-1:0]        mag_t;

    localparam mag_t MAG_SAT     = 62'h2000_0000_0000_0000;
    localparam sum_t SUM_SAT_POS = 64'sh2000_0000_0000_0000;
    localparam sum_t SUM_SAT_NEG = -64'sh2000_0000_0000_0000;

endpackage

`default_nettype wire

// ----- design/crpf_ram.sv -----
// ============================================================================
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
`default_nettype none

module crpf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/catmull_rom_path_follower.sv -----
// ============================================================================
// Catmull-Rom path follower
// Holds a table of 3-D control points and moves a camera along the spline
// through them, giving the position at t and the look target at t + 0.01.
// ============================================================================
//
// A load transaction writes one control point into the point memory and a
// restart transaction rewinds the path to segment 1 with t at zero; both are
// taken directly in the idle state and give no result. A tick transaction
// advances t by (speed * delta_time) >> 8 unless the path is paused, and
// produces exactly one result transaction. On a segment that needs the full
// spline a tick goes through the parameter update, reads the four
// neighbouring points out of the synchronous point memory, and then works
// through each axis in turn on the single shared 31 x 25 bit multiplier:
// each Horner step splits the 62-bit magnitude into two halves that go
// through it on consecutive cycles, and three steps are needed for the
// position and three for the look target. Near the ends of the path the
// result is simply a stored point, and when no points are in use it is zero.
// The input is not ready while a tick is being worked on; a finished result
// sits in an output register, so further load and restart transactions are
// taken while it waits to be collected. The point memory has no reset:
// reading an entry never loaded gives an undefined result. Configuration
// (speed, point_count) is written over a separate port that is always ready
// and should only be used while idle.
// ============================================================================
`default_nettype none

module catmull_rom_path_follower #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [1:0]         cmd,
    input  wire logic [3:0]         point_slot,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    input  wire logic [15:0]        delta_time,

    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] pos_x,
    output      logic signed [31:0] pos_y,
    output      logic signed [31:0] pos_z,
    output      logic signed [31:0] aim_x,
    output      logic signed [31:0] aim_y,
    output      logic signed [31:0] aim_z,
    output      logic               halted,
    output      logic [3:0]         segment,

    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int PW = 3 * COORD_BITS;

    // Signed range of a stored coordinate, extended to the datapath width.
    localparam crpf_pkg::acc_t CRD_HI =
        {{(crpf_pkg::ACC_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam crpf_pkg::acc_t CRD_LO = ~CRD_HI;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TINC = 4'd1;
    localparam logic [3:0] S_TUPD = 4'd2;
    localparam logic [3:0] S_SEL  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_RDW  = 4'd5;
    localparam logic [3:0] S_COEF = 4'd6;
    localparam logic [3:0] S_ABS  = 4'd7;
    localparam logic [3:0] S_MLO  = 4'd8;
    localparam logic [3:0] S_MHI  = 4'd9;
    localparam logic [3:0] S_COMB = 4'd10;
    localparam logic [3:0] S_ACC  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_PUB  = 4'd13;

    function automatic crpf_pkg::acc_t clamp_crd(input crpf_pkg::acc_t v);
        crpf_pkg::acc_t r;
        r = v;
        if (v > CRD_HI)
        begin
            r = CRD_HI;
        end
        else if (v < CRD_LO)
        begin
            r = CRD_LO;
        end
        return r;
    endfunction

    function automatic crpf_pkg::acc_t crd_ext(input logic [COORD_BITS-1:0] v);
        return crpf_pkg::acc_t'(signed'(v));
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [3:0]                        state_reg, state_next;
    logic [crpf_pkg::SPEED_W-1:0]      speed_reg;
    logic [crpf_pkg::IDX_W-1:0]        point_count_reg;
    logic [crpf_pkg::IDX_W-1:0]        seg_reg;
    logic [crpf_pkg::T_W-1:0]          t_reg;
    logic                              paused_reg;
    logic                              out_valid_reg;
    logic                              spline_reg;
    logic [1:0]                        rd_cnt_reg;
    logic [1:0]                        round_reg;
    logic [1:0]                        axis_reg;
    logic                              pass_reg;

    logic [15:0]                       dt_reg;
    logic [crpf_pkg::T_W-1:0]          inc_reg;
    logic [crpf_pkg::TE_W-1:0]         t_aim_reg;
    logic [crpf_pkg::IDX_W-1:0]        base_reg;
    logic [PW-1:0]                     p0_reg, p1_reg, p2_reg, p3_reg;
    crpf_pkg::acc_t                    b_reg, c_reg, d_reg, p1x2_reg;
    crpf_pkg::acc_t                    x_reg;
    logic                              neg_reg;
    crpf_pkg::mag_t                    mag_reg;
    logic [crpf_pkg::PP_W-1:0]         plo_reg, phi_reg;
    crpf_pkg::mag_t                    r_reg;
    logic signed [crpf_pkg::OUT_W-1:0] res_reg [6];
    logic signed [crpf_pkg::OUT_W-1:0] out_res_reg [6];
    logic                              halted_reg;
    logic [3:0]                        segment_reg;

    // ------------------------------------------------------------------------
    // Handshakes and point memory
    // ------------------------------------------------------------------------
    logic          in_take;
    logic          pub_ok;
    logic          ram_we;
    logic          ram_re;
    logic [PW-1:0] ram_wdata;
    logic [PW-1:0] ram_rdata;
    logic [AW-1:0] ram_raddr;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && in_ready;
    assign pub_ok    = !out_valid_reg || out_ready;

    // Loads beyond the table are dropped; coordinates are saturated to the
    // stored width before they are written.
    assign ram_we = in_take && (cmd == crpf_pkg::CMD_LOAD) &&
                    (32'(point_slot) < MAX_POINTS);
    assign ram_wdata = {clamp_crd(crpf_pkg::acc_t'(coord_z))[COORD_BITS-1:0],
                        clamp_crd(crpf_pkg::acc_t'(coord_y))[COORD_BITS-1:0],
                        clamp_crd(crpf_pkg::acc_t'(coord_x))[COORD_BITS-1:0]};
    assign ram_re    = (state_reg == S_RD);
    assign ram_raddr = AW'(crpf_pkg::IDX_W'(base_reg + crpf_pkg::IDX_W'(rd_cnt_reg)));

    crpf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (AW'(point_slot)),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Parameter update and segment selection
    // ------------------------------------------------------------------------
    logic [crpf_pkg::IDX_W-1:0] used_n;
    logic [31:0]                inc_prod;
    logic [crpf_pkg::TE_W-1:0]  t_sum;
    logic [crpf_pkg::T_W-1:0]   t_sat;
    logic                       can_adv;
    logic                       seg_past;
    logic                       seg_edge;

    assign used_n   = (32'(point_count_reg) < MAX_POINTS) ? point_count_reg
                                                           : crpf_pkg::IDX_W'(MAX_POINTS);
    assign inc_prod = 32'(speed_reg) * 32'(dt_reg);
    assign t_sum    = {1'b0, t_reg} + {1'b0, inc_reg};
    assign t_sat    = t_sum[crpf_pkg::T_W] ? crpf_pkg::T_MAX : t_sum[crpf_pkg::T_W-1:0];
    assign can_adv  = ({1'b0, seg_reg} + 6'd3) < {1'b0, used_n};
    assign seg_past = (seg_reg >= used_n);
    assign seg_edge = (seg_reg == '0) || (({1'b0, seg_reg} + 6'd2) >= {1'b0, used_n});

    // ------------------------------------------------------------------------
    // Spline datapath
    // ------------------------------------------------------------------------
    crpf_pkg::acc_t             q0, q1, q2, q3;
    logic [crpf_pkg::TE_W-1:0]  t_eval;
    logic [crpf_pkg::HALF_W-1:0] mul_a;
    logic [crpf_pkg::PP_W-1:0]  mul_p;
    logic [crpf_pkg::PROD_W-1:0] full_prod;
    crpf_pkg::mag_t             r_next;
    crpf_pkg::acc_t             coef_sel;
    crpf_pkg::sum_t             acc_sum;
    crpf_pkg::acc_t             acc_next;
    crpf_pkg::acc_t             half_sum;
    crpf_pkg::acc_t             fin_val;
    logic [2:0]                 res_idx;

    assign q0 = crd_ext(p0_reg[axis_reg * COORD_BITS +: COORD_BITS]);
    assign q1 = crd_ext(p1_reg[axis_reg * COORD_BITS +: COORD_BITS]);
    assign q2 = crd_ext(p2_reg[axis_reg * COORD_BITS +: COORD_BITS]);
    assign q3 = crd_ext(p3_reg[axis_reg * COORD_BITS +: COORD_BITS]);

    assign t_eval = pass_reg ? t_aim_reg : {1'b0, t_reg};

    // The one spline multiplier: low half of the magnitude in S_MLO, high half in S_MHI.
    assign mul_a = (state_reg == S_MHI) ? mag_reg[crpf_pkg::MAG_W-1:crpf_pkg::HALF_W]
                                        : mag_reg[crpf_pkg::HALF_W-1:0];
    assign mul_p = crpf_pkg::PP_W'(mul_a) * crpf_pkg::PP_W'(t_eval);

    // A product that does not fit 64 bits saturates; otherwise it is shifted
    // down by 16, which always leaves it well below the saturation level.
    assign full_prod = (crpf_pkg::PROD_W'(phi_reg) << crpf_pkg::HALF_W) +
                       crpf_pkg::PROD_W'(plo_reg);
    assign r_next = (|full_prod[crpf_pkg::PROD_W-1:64]) ? crpf_pkg::MAG_SAT
                                                         : crpf_pkg::MAG_W'(full_prod[63:16]);

    always_comb
    begin
        case (round_reg)
            2'd0:    coef_sel = c_reg;
            2'd1:    coef_sel = b_reg;
            default: coef_sel = p1x2_reg;
        endcase
    end

    assign acc_sum = neg_reg ? (crpf_pkg::SUM_W'(coef_sel) - signed'(crpf_pkg::SUM_W'(r_reg)))
                             : (crpf_pkg::SUM_W'(coef_sel) + signed'(crpf_pkg::SUM_W'(r_reg)));

    always_comb
    begin
        if (acc_sum > crpf_pkg::SUM_SAT_POS)
        begin
            acc_next = crpf_pkg::ACC_W'(crpf_pkg::SUM_SAT_POS);
        end
        else if (acc_sum < crpf_pkg::SUM_SAT_NEG)
        begin
            acc_next = crpf_pkg::ACC_W'(crpf_pkg::SUM_SAT_NEG);
        end
        else
        begin
            acc_next = crpf_pkg::ACC_W'(acc_sum);
        end
    end

    // Halving rounds toward zero: add one to a negative value before the shift.
    assign half_sum = x_reg + crpf_pkg::acc_t'({1'b0, x_reg[crpf_pkg::ACC_W-1]});
    assign fin_val  = clamp_crd(half_sum >>> 1);
    assign res_idx  = pass_reg ? (3'(axis_reg) + 3'd3) : 3'(axis_reg);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (cmd == crpf_pkg::CMD_TICK))
                begin
                    state_next = S_TINC;
                end
            end
            S_TINC: state_next = S_TUPD;
            S_TUPD: state_next = S_SEL;
            S_SEL:  state_next = (used_n == '0) ? S_PUB : S_RD;
            S_RD:   state_next = S_RDW;
            S_RDW:
            begin
                if (!spline_reg)
                begin
                    state_next = S_PUB;
                end
                else if (rd_cnt_reg == 2'd3)
                begin
                    state_next = S_COEF;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_COEF: state_next = S_ABS;
            S_ABS:  state_next = S_MLO;
            S_MLO:  state_next = S_MHI;
            S_MHI:  state_next = S_COMB;
            S_COMB: state_next = S_ACC;
            S_ACC:  state_next = (round_reg == 2'd2) ? S_FIN : S_ABS;
            S_FIN:
            begin
                if (!pass_reg)
                begin
                    state_next = S_ABS;
                end
                else if (axis_reg == 2'd2)
                begin
                    state_next = S_PUB;
                end
                else
                begin
                    state_next = S_COEF;
                end
            end
            S_PUB:  state_next = pub_ok ? S_IDLE : S_PUB;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            speed_reg       <= crpf_pkg::SPEED_RESET;
            point_count_reg <= '0;
            seg_reg         <= crpf_pkg::IDX_W'(1);
            t_reg           <= '0;
            paused_reg      <= 1'b1;
            out_valid_reg   <= 1'b0;
            spline_reg      <= 1'b0;
            rd_cnt_reg      <= '0;
            round_reg       <= '0;
            axis_reg        <= '0;
            pass_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    crpf_pkg::CFG_SPEED: speed_reg       <= cfg_data;
                    crpf_pkg::CFG_COUNT: point_count_reg <= cfg_data[crpf_pkg::IDX_W-1:0];
                    default: ;
                endcase
            end

            if (in_take && (cmd == crpf_pkg::CMD_RESTART))
            begin
                seg_reg    <= crpf_pkg::IDX_W'(1);
                t_reg      <= '0;
                paused_reg <= 1'b0;
            end

            // One tick moves at most one segment; at the last usable segment
            // the path stops instead and t keeps its saturated value.
            if ((state_reg == S_TUPD) && !paused_reg)
            begin
                if (t_sat >= crpf_pkg::T_ONE)
                begin
                    if (can_adv)
                    begin
                        seg_reg <= seg_reg + crpf_pkg::IDX_W'(1);
                        t_reg   <= t_sat - crpf_pkg::T_ONE;
                    end
                    else
                    begin
                        t_reg      <= t_sat;
                        paused_reg <= 1'b1;
                    end
                end
                else
                begin
                    t_reg <= t_sat;
                end
            end

            if (state_reg == S_SEL)
            begin
                spline_reg <= !seg_past && !seg_edge;
                rd_cnt_reg <= '0;
            end

            if ((state_reg == S_RDW) && spline_reg)
            begin
                rd_cnt_reg <= rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == 2'd3)
                begin
                    axis_reg <= '0;
                    pass_reg <= 1'b0;
                end
            end

            if (state_reg == S_COEF)
            begin
                round_reg <= '0;
                pass_reg  <= 1'b0;
            end

            if ((state_reg == S_ACC) && (round_reg != 2'd2))
            begin
                round_reg <= round_reg + 2'd1;
            end

            if (state_reg == S_FIN)
            begin
                round_reg <= '0;
                if (!pass_reg)
                begin
                    pass_reg <= 1'b1;
                end
                else
                begin
                    pass_reg <= 1'b0;
                    axis_reg <= axis_reg + 2'd1;
                end
            end

            if ((state_reg == S_PUB) && pub_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_take && (cmd == crpf_pkg::CMD_TICK))
        begin
            dt_reg <= delta_time;
        end

        case (state_reg)
            S_TINC:
            begin
                inc_reg <= inc_prod[31:8];
            end
            S_SEL:
            begin
                t_aim_reg <= {1'b0, t_reg} + crpf_pkg::AIM_OFFSET;
                if (seg_past)
                begin
                    base_reg <= used_n - crpf_pkg::IDX_W'(1);
                end
                else if (seg_edge)
                begin
                    base_reg <= seg_reg;
                end
                else
                begin
                    base_reg <= seg_reg - crpf_pkg::IDX_W'(1);
                end
                if (used_n == '0)
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        res_reg[k] <= '0;
                    end
                end
            end
            S_RDW:
            begin
                case (rd_cnt_reg)
                    2'd0:    p0_reg <= ram_rdata;
                    2'd1:    p1_reg <= ram_rdata;
                    2'd2:    p2_reg <= ram_rdata;
                    default: p3_reg <= ram_rdata;
                endcase
                if (!spline_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        res_reg[k]     <= crd_ext(ram_rdata[k * COORD_BITS +: COORD_BITS])
                                          [crpf_pkg::OUT_W-1:0];
                        res_reg[k + 3] <= crd_ext(ram_rdata[k * COORD_BITS +: COORD_BITS])
                                          [crpf_pkg::OUT_W-1:0];
                    end
                end
            end
            S_COEF:
            begin
                // Stored coordinates are narrow enough that none of these
                // sums can reach the saturation level.
                b_reg    <= q2 - q0;
                c_reg    <= (q0 <<< 1) - ((q1 <<< 2) + q1) + (q2 <<< 2) - q3;
                d_reg    <= ((q1 <<< 1) + q1) - ((q2 <<< 1) + q2) + q3 - q0;
                p1x2_reg <= q1 <<< 1;
                x_reg    <= ((q1 <<< 1) + q1) - ((q2 <<< 1) + q2) + q3 - q0;
            end
            S_ABS:
            begin
                neg_reg <= x_reg[crpf_pkg::ACC_W-1];
                mag_reg <= x_reg[crpf_pkg::ACC_W-1] ? crpf_pkg::MAG_W'(-x_reg)
                                                    : crpf_pkg::MAG_W'(x_reg);
            end
            S_MLO:
            begin
                plo_reg <= mul_p;
            end
            S_MHI:
            begin
                phi_reg <= mul_p;
            end
            S_COMB:
            begin
                r_reg <= r_next;
            end
            S_ACC:
            begin
                x_reg <= acc_next;
            end
            S_FIN:
            begin
                res_reg[res_idx] <= fin_val[crpf_pkg::OUT_W-1:0];
                if (!pass_reg)
                begin
                    x_reg <= d_reg;
                end
            end
            S_PUB:
            begin
                if (pub_ok)
                begin
                    for (int k = 0; k < 6; k++)
                    begin
                        out_res_reg[k] <= res_reg[k];
                    end
                    halted_reg  <= paused_reg;
                    segment_reg <= seg_reg[3:0];
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = out_res_reg[0];
    assign pos_y     = out_res_reg[1];
    assign pos_z     = out_res_reg[2];
    assign aim_x     = out_res_reg[3];
    assign aim_y     = out_res_reg[4];
    assign aim_z     = out_res_reg[5];
    assign halted    = halted_reg;
    assign segment   = segment_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MLO) |-> (mag_reg <= crpf_pkg::MAG_SAT))
        else $error("Multiplier operand above the saturation level.");

    a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg != '0)
        else $error("Segment index reached zero.");

    a_paused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_TUPD) && paused_reg) |=>
        ($stable(t_reg) && $stable(seg_reg) && paused_reg))
        else $error("Paused path moved during a tick.");

    a_out_from_pub: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PUB))
        else $error("Result offered outside the publish step.");

endmodule

`default_nettype wire
